@@ hw/rtl/srsw_pkg.sv @@
package srsw_pkg;

  localparam int unsigned Window   = 4;
  localparam int unsigned SeqCount = 8;  // power of two, at most 8
  localparam int unsigned SeqW     = (SeqCount > 1) ? $clog2(SeqCount) : 1;
  localparam int unsigned CntW     = SeqW + 1;
  localparam int unsigned WordW    = 64;

  typedef enum logic [1:0] {
    ActSend   = 2'd0,
    ActAck    = 2'd1,
    ActExpire = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    StSent      = 3'd0,
    StFull      = 3'd1,
    StNewAck    = 3'd2,
    StRepeatAck = 3'd3,
    StOutside   = 3'd4,
    StCorrupt   = 3'd5,
    StNothing   = 3'd6,
    StRetx      = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    TmrNone    = 2'd0,
    TmrStart   = 2'd1,
    TmrStop    = 2'd2,
    TmrRestart = 2'd3
  } timer_cmd_e;

  typedef enum logic [1:0] {
    StateIdle,
    StateExec
  } state_e;

  typedef struct packed {
    logic load_in;
    logic commit;
  } srsw_cmd_t;

endpackage

@@ hw/rtl/selective_repeat_sender_window.sv @@
// Selective-repeat ARQ sender window.
// Input channel (in_valid_i/in_ready_o) carries one command word: action
// (send, ack, timer expiry), payload, seq_num and the upstream checksum flag
// ack_intact. Output channel (out_valid_o/out_ready_i) returns exactly one
// result word per command: status, the packet to transmit (tx_*), the timer
// command for timer_seq, and the window base and in-flight count after it.
// A command is latched when accepted, and its result is registered once the
// result register is free; no new command is taken until then. The command
// is latched together with the payload memory read, and then the window
// update, including the slide of the base past the acknowledged run, is done.
// Payload words sit in an 8-entry memory with one write and one read port.
// The result register holds while the receiver stalls; the next command is
// still taken, and its result waits until the held word is taken.
// Reset clears the base, next sequence number and all acknowledge marks;
// the payload memory is not cleared, and an expiry reads it for any number.
module selective_repeat_sender_window (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [63:0] payload_i,
  input  logic [2:0]  seq_num_i,
  input  logic        ack_intact_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic        tx_valid_o,
  output logic [2:0]  tx_seq_o,
  output logic [63:0] tx_payload_o,
  output logic [1:0]  timer_cmd_o,
  output logic [2:0]  timer_seq_o,
  output logic [2:0]  window_base_o,
  output logic [2:0]  in_flight_o
);
  import srsw_pkg::*;

  srsw_cmd_t cmd;

  srsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  srsw_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .action_i     (action_i),
    .payload_i    (payload_i),
    .seq_num_i    (seq_num_i),
    .ack_intact_i (ack_intact_i),
    .status_o     (status_o),
    .tx_valid_o   (tx_valid_o),
    .tx_seq_o     (tx_seq_o),
    .tx_payload_o (tx_payload_o),
    .timer_cmd_o  (timer_cmd_o),
    .timer_seq_o  (timer_seq_o),
    .window_base_o(window_base_o),
    .in_flight_o  (in_flight_o)
  );

endmodule

@@ hw/rtl/srsw_ram.sv @@
module srsw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  logic [Width-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/srsw_ctrl.sv @@
module srsw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output srsw_pkg::srsw_cmd_t cmd_o
);
  import srsw_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StateIdle: begin
        if (in_valid_i) begin
          state_d = StateExec;
        end
      end
      StateExec: begin
        if (slot_free) begin
          state_d = StateIdle;
        end
      end
      default: state_d = StateIdle;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.load_in = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      StateIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      StateExec: begin
        cmd_o.commit = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/srsw_dp.sv @@
module srsw_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srsw_pkg::srsw_cmd_t cmd_i,
  input  logic [1:0]          action_i,
  input  logic [63:0]         payload_i,
  input  logic [2:0]          seq_num_i,
  input  logic                ack_intact_i,
  output logic [2:0]          status_o,
  output logic                tx_valid_o,
  output logic [2:0]          tx_seq_o,
  output logic [63:0]         tx_payload_o,
  output logic [1:0]          timer_cmd_o,
  output logic [2:0]          timer_seq_o,
  output logic [2:0]          window_base_o,
  output logic [2:0]          in_flight_o
);
  import srsw_pkg::*;

  // latched word
  logic [1:0]       action_q;
  logic [WordW-1:0] payload_q;
  logic [SeqW-1:0]  seq_q;
  logic             intact_q;

  // window state
  logic [SeqW-1:0]     base_q, base_d;
  logic [SeqW-1:0]     next_q, next_d;
  logic [SeqCount-1:0] marks_q, marks_d;

  // result registers
  status_e          status_q, status_d;
  logic             txv_q, txv_d;
  logic [SeqW-1:0]  txs_q, txs_d;
  logic [WordW-1:0] txp_q, txp_d;
  timer_cmd_e       tcmd_q, tcmd_d;
  logic [SeqW-1:0]  tseq_q, tseq_d;

  logic [WordW-1:0]    rd_word;
  logic                ram_we;
  logic [SeqW-1:0]     inflight, off, step;
  logic [SeqCount-1:0] marks_set, rot;
  logic                run;

  assign inflight = next_q - base_q;
  assign off      = seq_q - base_q;

  srsw_ram #(
    .Width(WordW),
    .Depth(SeqCount)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(next_q),
    .wdata_i(payload_q),
    .re_i   (cmd_i.load_in),
    .raddr_i(seq_num_i[SeqW-1:0]),
    .rdata_o(rd_word)
  );

  always_comb begin
    marks_set = marks_q;
    marks_set[seq_q] = 1'b1;
    for (int unsigned i = 0; i < SeqCount; i++) begin
      rot[i] = marks_set[SeqW'(base_q + SeqW'(i))];
    end
    // length of the acknowledged run starting at the base
    step = '0;
    run  = 1'b1;
    for (int unsigned i = 0; i < SeqCount; i++) begin
      if (run && rot[i]) begin
        step = step + SeqW'(1);
      end else begin
        run = 1'b0;
      end
    end
  end

  always_comb begin
    base_d   = base_q;
    next_d   = next_q;
    marks_d  = marks_q;
    ram_we   = 1'b0;
    status_d = StRetx;
    txv_d    = 1'b0;
    txs_d    = '0;
    txp_d    = '0;
    tcmd_d   = TmrNone;
    tseq_d   = '0;
    case (action_q)
      ActSend: begin
        if (CntW'(inflight) >= CntW'(Window)) begin
          status_d = StFull;
        end else begin
          status_d = StSent;
          ram_we   = cmd_i.commit;
          next_d   = next_q + SeqW'(1);
          txv_d    = 1'b1;
          txs_d    = next_q;
          txp_d    = payload_q;
          tcmd_d   = TmrStart;
          tseq_d   = next_q;
        end
      end
      ActAck: begin
        if (base_q == next_q) begin
          status_d = StNothing;
        end else if (!intact_q) begin
          status_d = StCorrupt;
        end else if (off >= inflight) begin
          status_d = StOutside;
        end else begin
          if (marks_q[seq_q]) begin
            status_d = StRepeatAck;
          end else begin
            status_d = StNewAck;
            tcmd_d   = TmrStop;
            tseq_d   = seq_q;
          end
          base_d = base_q + step;
          for (int unsigned i = 0; i < SeqCount; i++) begin
            marks_d[i] = marks_set[i] && !(SeqW'(SeqW'(i) - base_q) < step);
          end
          // a full run of every number clears all marks
          if (step == '0 && rot[0]) begin
            marks_d = '0;
          end
        end
      end
      default: begin
        status_d = StRetx;
        txv_d    = 1'b1;
        txs_d    = seq_q;
        txp_d    = rd_word;
        tcmd_d   = TmrRestart;
        tseq_d   = seq_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      action_q  <= action_i;
      payload_q <= payload_i;
      seq_q     <= seq_num_i[SeqW-1:0];
      intact_q  <= ack_intact_i;
    end
    if (cmd_i.commit) begin
      status_q <= status_d;
      txv_q    <= txv_d;
      txs_q    <= txs_d;
      txp_q    <= txp_d;
      tcmd_q   <= tcmd_d;
      tseq_q   <= tseq_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      next_q  <= '0;
      marks_q <= '0;
    end else if (cmd_i.commit) begin
      base_q  <= base_d;
      next_q  <= next_d;
      marks_q <= marks_d;
    end
  end

  assign status_o      = status_q;
  assign tx_valid_o    = txv_q;
  assign tx_seq_o      = 3'(txs_q);
  assign tx_payload_o  = txp_q;
  assign timer_cmd_o   = tcmd_q;
  assign timer_seq_o   = 3'(tseq_q);
  assign window_base_o = 3'(base_q);
  assign in_flight_o   = 3'(next_q - base_q);

endmodule
